>>> design/checked_config_frame_deframer_assert.svh
// Assertion macros shared by the checker of the frame deframer.
// Each macro wraps one concurrent assertion clocked on a rising edge.
`ifndef CHECKED_CONFIG_FRAME_DEFRAMER_ASSERT_SVH
`define CHECKED_CONFIG_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while dis is high
`define CDF_ASSERT_IMPLY(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("cdf assertion failed");

// Next-cycle implication, disabled while dis is high
`define CDF_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("cdf assertion failed");

`endif

>>> design/cdf_pkg.sv
// Shared constants and types of the checked configuration frame deframer.
// Used by cdf_ctrl, cdf_store, cdf_port_checker and the top level; no dependencies.
`timescale 1ns / 1ps
package cdf_pkg;

  localparam int unsigned FRAME_BYTES = 37;
  localparam int unsigned SUM_BYTES   = 33;
  // Bytes 1..35 are held; the header is not needed and byte 36 is live on the input
  localparam int unsigned STORE_DEPTH = FRAME_BYTES - 2;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned SUM_W       = 14;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned OUT_DATA_W  = 288;

  // Unpacked frame contents plus the trailing check word
  typedef struct packed {
    logic [31:0] check_word;
    logic [31:0] stop_time_bits;
    logic [31:0] gain_d_bits;
    logic [31:0] gain_i_bits;
    logic [31:0] gain_p_bits;
    logic [31:0] wire_resistance_bits;
    logic [15:0] log_speed;
    logic [15:0] log_buffer_size;
    logic [23:0] control_bytes;
    logic [31:0] setpoint_bits;
    logic [7:0]  length_byte;
  } cdf_fields_t;

  // Status from the frame controller
  typedef struct packed {
    logic             capturing;
    logic             done;
    logic             ok;
    logic [CNT_W-1:0] count;
  } cdf_verdict_t;

endpackage

>>> design/cdf_store.sv
// Frame byte shift line of the deframer: holds frame bytes 1..35 and
// unpacks them at fixed taps. Depends on cdf_pkg.
`timescale 1ns / 1ps
module cdf_store
  import cdf_pkg::*;
(
  input  logic        clk,
  input  logic        shift_en,
  input  logic [7:0]  rx_byte,
  output cdf_fields_t fields
);

  logic [7:0] line_r [STORE_DEPTH];

  // Advance the line; the newest byte enters at the top, so byte k sits at k-1
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
        line_r[i] <= line_r[i+1];
      end
      line_r[STORE_DEPTH-1] <= rx_byte;
    end
  end

  // Unpack little-endian fields; the last check byte is the live input
  always_comb begin
    fields.length_byte          = line_r[0];
    fields.setpoint_bits        = {line_r[4], line_r[3], line_r[2], line_r[1]};
    fields.control_bytes        = {line_r[7], line_r[6], line_r[5]};
    fields.log_buffer_size      = {line_r[9], line_r[8]};
    fields.log_speed            = {line_r[11], line_r[10]};
    fields.wire_resistance_bits = {line_r[15], line_r[14], line_r[13], line_r[12]};
    fields.gain_p_bits          = {line_r[19], line_r[18], line_r[17], line_r[16]};
    fields.gain_i_bits          = {line_r[23], line_r[22], line_r[21], line_r[20]};
    fields.gain_d_bits          = {line_r[27], line_r[26], line_r[25], line_r[24]};
    fields.stop_time_bits       = {line_r[31], line_r[30], line_r[29], line_r[28]};
    fields.check_word           = {rx_byte, line_r[34], line_r[33], line_r[32]};
  end

endmodule

>>> design/cdf_ctrl.sv
// Frame controller of the deframer: header hunt, byte position, running
// sum, checksum compare and pass/fail totals. Depends on cdf_pkg.
`timescale 1ns / 1ps
module cdf_ctrl
  import cdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         take,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   header_byte,
  input  logic [31:0]  check_word,
  output cdf_verdict_t verdict
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] SUM_END  = POS_W'(SUM_BYTES);

  logic             capturing_r, capturing_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] accepted_r, accepted_nxt;
  logic [CNT_W-1:0] rejected_r, rejected_nxt;
  logic             done;
  logic             ok;

  // Last byte of a frame: bytes 0..32 are already summed
  assign done = take && capturing_r && (pos_r == LAST_POS);
  assign ok   = ({{(32 - SUM_W){1'b0}}, sum_r} == check_word);

  assign verdict.capturing = capturing_r;
  assign verdict.done      = done;
  assign verdict.ok        = ok;
  assign verdict.count     = ok ? accepted_r + 1'b1 : rejected_r + 1'b1;

  // Hunt, capture and close frames
  always_comb begin
    capturing_nxt = capturing_r;
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    accepted_nxt  = accepted_r;
    rejected_nxt  = rejected_r;
    if (take) begin
      if (!capturing_r) begin
        if (rx_byte == header_byte) begin
          capturing_nxt = 1'b1;
          pos_nxt       = POS_W'(1);
          sum_nxt       = SUM_W'(rx_byte);
        end
      end else if (done) begin
        capturing_nxt = 1'b0;
        pos_nxt       = '0;
        sum_nxt       = '0;
        if (ok) begin
          accepted_nxt = accepted_r + 1'b1;
        end else begin
          rejected_nxt = rejected_r + 1'b1;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < SUM_END) begin
          sum_nxt = sum_r + SUM_W'(rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      pos_r       <= '0;
      sum_r       <= '0;
      accepted_r  <= '0;
      rejected_r  <= '0;
    end else begin
      capturing_r <= capturing_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      accepted_r  <= accepted_nxt;
      rejected_r  <= rejected_nxt;
    end
  end

endmodule

>>> design/checked_config_frame_deframer.sv
// Checked configuration frame deframer, top level.
//
// in_*  : one received serial byte per request (in_tdata[7:0]).
// out_* : one request per completed 37-byte frame; out_tuser is the pass
//         flag, out_tdata carries the updated pass or fail total and the
//         unpacked frame fields.
// cfg_* : cfg_wr_en writes cfg_wr_data into the header byte register.
//
// While hunting, bytes that differ from the header byte are dropped. A
// matching byte opens a frame; the next 36 bytes complete it. Bytes 0..32
// are summed and compared with the little-endian word in bytes 33..36.
// Throughput is one byte per cycle while in_tready is high; the result is
// valid in the cycle after the last frame byte is accepted, from a single
// output register. in_tready stays high while the output register is empty
// or being drained, so a stalled receiver blocks input only once a result
// is waiting. Reset (rst_n low, synchronous) clears the header byte to zero,
// the totals, the hunt state and the output valid; in_tready is low during
// reset. Depends on cdf_pkg, cdf_ctrl and cdf_store.
`timescale 1ns / 1ps
module checked_config_frame_deframer
  import cdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // rx_byte [7:0]
  input  logic [7:0]            in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // frame_count [31:0], length_byte [39:32], setpoint_bits [71:40],
  // control_bytes [95:72], log_buffer_size [111:96], log_speed [127:112],
  // wire_resistance_bits [159:128], gain_p_bits [191:160],
  // gain_i_bits [223:192], gain_d_bits [255:224], stop_time_bits [287:256]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // frame_ok [0]
  output logic                  out_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data
);

  logic [7:0]            header_byte_r;
  logic                  take;
  cdf_verdict_t          verdict;
  cdf_fields_t           fields;
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign take      = in_tvalid && in_tready;

  // Hold the header byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= '0;
    end else if (cfg_wr_en) begin
      header_byte_r <= cfg_wr_data;
    end
  end

  cdf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .rx_byte     (in_tdata),
    .header_byte (header_byte_r),
    .check_word  (fields.check_word),
    .verdict     (verdict)
  );

  cdf_store u_store (
    .clk      (clk),
    .shift_en (take && verdict.capturing),
    .rx_byte  (in_tdata),
    .fields   (fields)
  );

  // Pack the result request
  assign out_data_nxt = {fields.stop_time_bits, fields.gain_d_bits, fields.gain_i_bits,
                         fields.gain_p_bits, fields.wire_resistance_bits, fields.log_speed,
                         fields.log_buffer_size, fields.control_bytes, fields.setpoint_bits,
                         fields.length_byte, verdict.count};

  // Output register: load on frame end, clear when drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (verdict.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.done) begin
      out_ok_r   <= verdict.ok;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/cdf_port_checker.sv
// Port-level checker of the frame deframer, bound to the top level.
// Depends on checked_config_frame_deframer_assert.svh and cdf_pkg.
`timescale 1ns / 1ps
`include "checked_config_frame_deframer_assert.svh"
module cdf_port_checker
  import cdf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready
);

  // Reset empties the output register
  `CDF_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_tvalid)
  // A result request never appears without an input request before it
  `CDF_ASSERT_IMPLY(a_out_from_in, clk, !rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready))
  // A waiting, stalled result blocks the input side
  `CDF_ASSERT_IMPLY(a_stall_blocks, clk, !rst_n, out_tvalid && !out_tready, !in_tready)
  // A stalled result stays offered and unchanged
  `CDF_ASSERT_NEXT(a_valid_hold, clk, !rst_n, out_tvalid && !out_tready, out_tvalid)
  `CDF_ASSERT_NEXT(a_data_hold, clk, !rst_n, out_tvalid && !out_tready, $stable(out_tdata))

endmodule

bind checked_config_frame_deframer cdf_port_checker u_cdf_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
